/* src/bfla_pkg.sv */
// Shared types and constants for the block free list allocator.
// Used by the top level, including its RAM instance wiring; no dependencies.
`default_nettype none

package bfla_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = 11;
   localparam int ADDR_W     = $clog2(MAX_BLOCKS);
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int REQ_DW     = 16;
   localparam int RSP_DW     = 24;

   localparam logic [IDX_W-1:0] IDX_MAX   = {IDX_W{1'b1}};
   localparam logic [IDX_W-1:0] COUNT_CAP = IDX_W'(MAX_BLOCKS);
   localparam logic [IDX_W-1:0] COUNT_RST = IDX_W'(1024);

   localparam logic [CSR_AW-3:0] REG_BLOCK_COUNT = '0;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

endpackage

`default_nettype wire

/* src/bfla_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
`default_nettype none

module bfla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* src/block_free_list_allocator.sv */
// Fixed-size block allocator: LIFO free list with links in a RAM, plus a bump mark.
// Depends on bfla_pkg and bfla_ram.
// A result is registered at the edge that accepts its item; an allocate that pops the
// free list passes through the pop state first, since the next link comes from the RAM read.
// Throughput: one item per cycle for frees and bump or failed allocates while results are
// taken; allocates served from the free list hold off new items during the pop state.
// Reset (synchronous): list empty, bump mark and used count zero, block_count 1024.
`default_nettype none

module block_free_list_allocator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request item.
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [bfla_pkg::REQ_DW-1:0]  req_tdata,  // block_index[10:0], zeros
   input  wire logic                         req_tuser,  // operation[0]
   // Result item.
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [bfla_pkg::RSP_DW-1:0]  rsp_tdata,  // granted_index[10:0], used_count[21:11]
   output logic      [1:0]                   rsp_tuser,  // status[1:0]
   // Configuration port.
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [bfla_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [bfla_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [bfla_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                              csr_pready
);

   import bfla_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] block_count_ff, block_count_in;
   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [IDX_W-1:0] bump_mark_ff, bump_mark_in;
   logic [IDX_W-1:0] in_use_ff, in_use_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_grant_ff, rsp_grant_in;
   logic [IDX_W-1:0] rsp_used_ff, rsp_used_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             req_fire;
   op_type           req_op;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] count_eff;
   logic [IDX_W-1:0] idx_less;
   logic [IDX_W-1:0] head_less;
   logic [IDX_W-1:0] bump_plus;
   logic [IDX_W-1:0] used_inc;
   logic             csr_write;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [IDX_W-1:0]  ram_rd_data;

   assign req_op     = op_type'(req_tuser);
   assign req_idx    = req_tdata[IDX_W-1:0];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign count_eff = (block_count_ff > COUNT_CAP) ? COUNT_CAP : block_count_ff;
   assign idx_less  = req_idx - IDX_W'(1);
   assign head_less = free_head_ff - IDX_W'(1);
   assign bump_plus = bump_mark_ff + IDX_W'(1);
   assign used_inc  = (in_use_ff < IDX_MAX) ? in_use_ff + IDX_W'(1) : in_use_ff;

   assign ram_wr_addr = idx_less[ADDR_W-1:0];
   assign ram_rd_addr = head_less[ADDR_W-1:0];

   bfla_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (free_head_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_BLOCK_COUNT)
                       ? CSR_DW'(block_count_ff) : '0;

   always_comb begin
      block_count_in = block_count_ff;
      if (csr_write && (csr_paddr[CSR_AW-1:2] == REG_BLOCK_COUNT)) begin
         block_count_in = csr_pwdata[IDX_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_op == OP_ALLOC) && (free_head_ff != '0)) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      free_head_in  = free_head_ff;
      bump_mark_in  = bump_mark_ff;
      in_use_in     = in_use_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_grant_in  = rsp_grant_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_ALLOC: begin
                     if (free_head_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        if (bump_mark_ff < count_eff) begin
                           bump_mark_in  = bump_plus;
                           in_use_in     = used_inc;
                           rsp_grant_in  = bump_plus;
                           rsp_used_in   = used_inc;
                           rsp_status_in = STATUS_OK;
                        end else begin
                           rsp_grant_in  = '0;
                           rsp_used_in   = in_use_ff;
                           rsp_status_in = STATUS_EXHAUSTED;
                        end
                     end
                  end
                  OP_FREE: begin
                     rsp_valid_in = 1'b1;
                     rsp_grant_in = '0;
                     if ((req_idx == '0) || (req_idx > count_eff)) begin
                        rsp_used_in   = in_use_ff;
                        rsp_status_in = STATUS_BAD_INDEX;
                     end else begin
                        ram_wr_en     = 1'b1;
                        free_head_in  = req_idx;
                        in_use_in     = (in_use_ff != '0) ? in_use_ff - IDX_W'(1) : in_use_ff;
                        rsp_used_in   = in_use_in;
                        rsp_status_in = STATUS_OK;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  end
               endcase
            end
         end
         ST_POP: begin
            free_head_in  = ram_rd_data;
            in_use_in     = used_inc;
            rsp_valid_in  = 1'b1;
            rsp_grant_in  = free_head_ff;
            rsp_used_in   = used_inc;
            rsp_status_in = STATUS_OK;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_tready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         block_count_ff <= COUNT_RST;
         free_head_ff   <= '0;
         bump_mark_ff   <= '0;
         in_use_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         free_head_ff   <= free_head_in;
         bump_mark_ff   <= bump_mark_in;
         in_use_ff      <= in_use_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_grant_ff  <= rsp_grant_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({rsp_used_ff, rsp_grant_ff});
   assign rsp_tuser  = rsp_status_ff;

   // A pop cycle must find the result register empty, or a result would be lost.
   a_pop_output_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> !rsp_valid_ff)
      else $error("pop cycle with a pending result");

   // A pop always finishes in the following cycle.
   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (state_ff == ST_IDLE))
      else $error("pop did not finish");

   // A successful free makes the freed index the new list head.
   a_free_sets_head: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> (free_head_ff == $past(req_idx)))
      else $error("free did not update the list head");

   // A nonzero grant is always reported with an ok status.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_grant_ff != '0)) |-> (rsp_status_ff == STATUS_OK))
      else $error("grant with failing status");

endmodule

`default_nettype wire
